// File: hw/rtl/sensor_health_monitor_unit_defines.svh
// Assertion macros used by the top block of the sensor health monitor.
`ifndef SENSOR_HEALTH_MONITOR_UNIT_DEFINES_SVH
`define SENSOR_HEALTH_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define SHM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sensor health monitor: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define SHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sensor health monitor: next-cycle check failed");

`endif

// File: hw/rtl/shm_pkg.sv
package shm_pkg;

    localparam int SENSOR_COUNT_DEF = 11;
    localparam int TIME_WIDTH_DEF   = 32;
    localparam int HYST_WIDTH       = 12;
    localparam int ID_WIDTH         = 4;
    localparam int TEMP_WIDTH       = 16;
    localparam int TIMEOUT_WIDTH    = 13;

    localparam logic [HYST_WIDTH-1:0] HYST_RESET = 12'd500;

    typedef enum logic [1:0] {
        REQ_SUCCESS = 2'd0,
        REQ_FAILURE = 2'd1,
        REQ_SWEEP   = 2'd2
    } req_kind_t;

    typedef enum logic [1:0] {
        HS_HEALTHY   = 2'd0,
        HS_WARNING   = 2'd1,
        HS_RECOVERY  = 2'd2,
        HS_PERMANENT = 2'd3
    } health_t;

    // Command handed from cell to cell; the time stamp travels beside it.
    typedef struct packed {
        logic [1:0]                   req;
        logic [ID_WIDTH-1:0]          sensor_id;
        logic signed [TEMP_WIDTH-1:0] temp;
    } cmd_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0] sensor;
        logic [1:0]          state;
        logic [3:0]          rec_count;
        logic [7:0]          err_count;
        logic                cold;
        logic                enabled;
        logic                reset_req;
        logic                bad_id;
        logic                last;
    } res_t;

    function automatic logic [TIMEOUT_WIDTH-1:0] timeout_ms(input logic [ID_WIDTH-1:0] idx);
        logic [TIMEOUT_WIDTH-1:0] t;
        case (idx)
            4'd0:                t = 13'd100;
            4'd1:                t = 13'd500;
            4'd2:                t = 13'd1000;
            4'd3, 4'd4, 4'd5:    t = 13'd5000;
            default:             t = 13'd3000;
        endcase
        return t;
    endfunction

    function automatic logic [1:0] max_recoveries(input logic [ID_WIDTH-1:0] idx);
        logic [1:0] m;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd6, 4'd7, 4'd8: m = 2'd2;
            4'd3:                               m = 2'd3;
            default:                            m = 2'd1;
        endcase
        return m;
    endfunction

    function automatic logic signed [TEMP_WIDTH-1:0] cold_limit(input logic [ID_WIDTH-1:0] idx);
        logic signed [TEMP_WIDTH-1:0] m;
        case (idx)
            4'd4:    m = -16'sd1000;
            4'd5:    m = -16'sd500;
            4'd7:    m = -16'sd2000;
            4'd8:    m = -16'sd9000;
            default: m = -16'sd4000;
        endcase
        return m;
    endfunction

endpackage

// File: hw/rtl/sensor_health_monitor_unit.sv
// A report's command walks the row of per-sensor cells; sensor k's cell gives its result,
// which is registered at the output. A sweep gives one result per cycle while the output is not
// stalled, in sensor order. A bad id's result is registered straight from the input. The row
// takes a new item only once the last one has left the last cell; a bad id or an unused
// code frees the input at once. Output stalls hold the whole row.
// Reset: all sensors healthy and enabled, counts and times zero, hysteresis 500.
`include "sensor_health_monitor_unit_defines.svh"

module sensor_health_monitor_unit #(
    parameter int SENSOR_COUNT = shm_pkg::SENSOR_COUNT_DEF,
    parameter int TIME_WIDTH   = shm_pkg::TIME_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [shm_pkg::HYST_WIDTH-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          req_type,
    input  logic [shm_pkg::ID_WIDTH-1:0]        sensor_id,
    input  logic [31:0]                         now_ms,
    input  logic signed [shm_pkg::TEMP_WIDTH-1:0] ext_temp,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [shm_pkg::ID_WIDTH-1:0]        result_sensor,
    output logic [1:0]                          health_state,
    output logic [3:0]                          retry_count,
    output logic [7:0]                          fault_count,
    output logic                                cold_disabled,
    output logic                                sensor_enabled,
    output logic                                reset_request,
    output logic                                bad_id,
    output logic                                last_result
);

    logic [shm_pkg::HYST_WIDTH-1:0] hyst_reg;
    logic                           out_valid_reg, out_valid_next;
    shm_pkg::res_t                  res_reg, res_next;

    logic                           advance;
    logic                           in_accept;
    logic                           is_report;
    logic                           id_bad;
    logic                           enter;
    shm_pkg::cmd_t                  head_cmd;
    shm_pkg::res_t                  bad_res;
    shm_pkg::res_t                  cell_res_sel;

    logic [SENSOR_COUNT-1:0]        chain_valid;
    logic [SENSOR_COUNT-1:0]        cell_fire;
    shm_pkg::cmd_t                  chain_cmd [SENSOR_COUNT];
    logic [TIME_WIDTH-1:0]          chain_now [SENSOR_COUNT];
    shm_pkg::res_t                  cell_res  [SENSOR_COUNT];

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !(|chain_valid) && advance;
    assign in_accept = in_valid && in_ready;

    assign is_report = (req_type == shm_pkg::REQ_SUCCESS) || (req_type == shm_pkg::REQ_FAILURE);
    assign id_bad    = ({1'b0, sensor_id} >= 5'(SENSOR_COUNT));
    assign enter     = in_accept && ((is_report && !id_bad) || req_type == shm_pkg::REQ_SWEEP);

    assign head_cmd.req       = req_type;
    assign head_cmd.sensor_id = sensor_id;
    assign head_cmd.temp      = ext_temp;

    always_comb
    begin
        bad_res           = '0;
        bad_res.sensor    = sensor_id;
        bad_res.state     = shm_pkg::HS_PERMANENT;
        bad_res.bad_id    = 1'b1;
        bad_res.last      = 1'b1;
    end

    for (genvar i = 0; i < SENSOR_COUNT; i++)
    begin : g_cell
        shm_cell #(
            .IDX        (i),
            .IS_LAST    ((i == SENSOR_COUNT - 1) ? 1 : 0),
            .TIME_WIDTH (TIME_WIDTH)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .advance       (advance),
            .hyst          (hyst_reg),
            .cmd_in_valid  ((i == 0) ? enter : chain_valid[(i == 0) ? 0 : i - 1]),
            .cmd_in        ((i == 0) ? head_cmd : chain_cmd[(i == 0) ? 0 : i - 1]),
            .now_in        ((i == 0) ? now_ms[TIME_WIDTH-1:0] : chain_now[(i == 0) ? 0 : i - 1]),
            .cmd_out_valid (chain_valid[i]),
            .cmd_out       (chain_cmd[i]),
            .now_out       (chain_now[i]),
            .fire          (cell_fire[i]),
            .res           (cell_res[i])
        );
    end

    // At most one cell holds the command, so this selects its result.
    always_comb
    begin
        cell_res_sel = '0;
        for (int i = 0; i < SENSOR_COUNT; i++)
        begin
            if (cell_fire[i])
            begin
                cell_res_sel = cell_res[i];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (advance)
        begin
            out_valid_next = 1'b0;
            if (|cell_fire)
            begin
                out_valid_next = 1'b1;
                res_next       = cell_res_sel;
            end
            else if (in_accept && is_report && id_bad)
            begin
                out_valid_next = 1'b1;
                res_next       = bad_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg      <= shm_pkg::HYST_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hyst_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid      = out_valid_reg;
    assign result_sensor  = res_reg.sensor;
    assign health_state   = res_reg.state;
    assign retry_count    = res_reg.rec_count;
    assign fault_count    = res_reg.err_count;
    assign cold_disabled  = res_reg.cold;
    assign sensor_enabled = res_reg.enabled;
    assign reset_request  = res_reg.reset_req;
    assign bad_id         = res_reg.bad_id;
    assign last_result    = res_reg.last;

    `SHM_ASSERT_NOW(a_one_item_in_row, clk, rst_n, 1'b1, $onehot0(chain_valid))
    `SHM_ASSERT_NOW(a_one_cell_fires, clk, rst_n, 1'b1, $onehot0(cell_fire))
    `SHM_ASSERT_NEXT(a_sweep_enters_row, clk, rst_n,
        in_accept && req_type == shm_pkg::REQ_SWEEP, chain_valid[0])
    `SHM_ASSERT_NEXT(a_bad_id_answers, clk, rst_n,
        in_accept && is_report && id_bad, out_valid_reg && res_reg.bad_id)

endmodule

// File: hw/rtl/shm_cell.sv
module shm_cell #(
    parameter int IDX        = 0,
    parameter int IS_LAST    = 0,
    parameter int TIME_WIDTH = shm_pkg::TIME_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic [shm_pkg::HYST_WIDTH-1:0]    hyst,
    input  logic                              cmd_in_valid,
    input  shm_pkg::cmd_t                     cmd_in,
    input  logic [TIME_WIDTH-1:0]             now_in,
    output logic                              cmd_out_valid,
    output shm_pkg::cmd_t                     cmd_out,
    output logic [TIME_WIDTH-1:0]             now_out,
    output logic                              fire,
    output shm_pkg::res_t                     res
);

    localparam logic [shm_pkg::ID_WIDTH-1:0] MyId = shm_pkg::ID_WIDTH'(IDX);
    localparam logic [shm_pkg::TIMEOUT_WIDTH-1:0] Timeout = shm_pkg::timeout_ms(MyId);
    localparam logic [1:0] MaxRec = shm_pkg::max_recoveries(MyId);
    localparam logic signed [shm_pkg::TEMP_WIDTH-1:0] MinT = shm_pkg::cold_limit(MyId);

    logic                  valid_reg;
    shm_pkg::cmd_t         cmd_reg;
    logic [TIME_WIDTH-1:0] now_reg;

    logic [1:0]            state_reg, state_next;
    logic [3:0]            rec_reg, rec_next;
    logic [7:0]            err_reg, err_next;
    logic [TIME_WIDTH-1:0] lgt_reg, lgt_next;
    logic                  en_reg, en_next;
    logic                  cold_reg, cold_next;

    logic                  is_sweep;
    logic                  hit;
    logic                  reset_req;
    logic                  too_cold;
    logic                  warm_again;
    logic                  timed_out;
    logic signed [17:0]    warm_thr;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [3:0]            rec_inc;

    assign is_sweep = (cmd_reg.req == shm_pkg::REQ_SWEEP);
    assign hit      = valid_reg && (is_sweep || (cmd_reg.sensor_id == MyId));
    assign fire     = hit && advance;

    assign warm_thr   = 18'(MinT) + $signed({6'b0, hyst});
    assign too_cold   = (cmd_reg.temp < MinT);
    assign warm_again = (18'(cmd_reg.temp) > warm_thr);
    assign elapsed    = now_reg - lgt_reg;
    assign timed_out  = (elapsed > TIME_WIDTH'(Timeout));
    assign rec_inc    = (rec_reg == 4'hF) ? rec_reg : rec_reg + 4'd1;

    always_comb
    begin
        state_next = state_reg;
        rec_next   = rec_reg;
        err_next   = err_reg;
        lgt_next   = lgt_reg;
        en_next    = en_reg;
        cold_next  = cold_reg;
        reset_req  = 1'b0;
        if (is_sweep)
        begin
            if (too_cold && !cold_reg)
            begin
                cold_next  = 1'b1;
                en_next    = 1'b0;
                state_next = shm_pkg::HS_WARNING;
            end
            else if (cold_reg && warm_again)
            begin
                cold_next  = 1'b0;
                en_next    = 1'b1;
                rec_next   = 4'd0;
                lgt_next   = now_reg;
                state_next = shm_pkg::HS_RECOVERY;
                reset_req  = 1'b1;
            end
            else if (en_reg && state_reg != shm_pkg::HS_PERMANENT && timed_out)
            begin
                lgt_next   = now_reg;
                rec_next   = rec_inc;
                state_next = (rec_inc >= {2'b00, MaxRec}) ? shm_pkg::HS_PERMANENT
                                                          : shm_pkg::HS_RECOVERY;
                reset_req  = 1'b1;
            end
        end
        else if (cmd_reg.req == shm_pkg::REQ_SUCCESS)
        begin
            lgt_next = now_reg;
            err_next = 8'd0;
            if (state_reg == shm_pkg::HS_WARNING || state_reg == shm_pkg::HS_RECOVERY)
            begin
                state_next = shm_pkg::HS_HEALTHY;
                rec_next   = 4'd0;
            end
        end
        else if (err_reg != 8'hFF)
        begin
            err_next = err_reg + 8'd1;
        end
    end

    always_comb
    begin
        res.sensor    = MyId;
        res.state     = state_next;
        res.rec_count = rec_next;
        res.err_count = err_next;
        res.cold      = cold_next;
        res.enabled   = en_next;
        res.reset_req = reset_req;
        res.bad_id    = 1'b0;
        // A report ends at its own cell; a sweep ends at the last cell.
        res.last      = !is_sweep || (IS_LAST != 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            state_reg <= shm_pkg::HS_HEALTHY;
            rec_reg   <= 4'd0;
            err_reg   <= 8'd0;
            lgt_reg   <= '0;
            en_reg    <= 1'b1;
            cold_reg  <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= cmd_in_valid;
            if (hit)
            begin
                state_reg <= state_next;
                rec_reg   <= rec_next;
                err_reg   <= err_next;
                lgt_reg   <= lgt_next;
                en_reg    <= en_next;
                cold_reg  <= cold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cmd_reg <= cmd_in;
            now_reg <= now_in;
        end
    end

    assign cmd_out_valid = valid_reg;
    assign cmd_out       = cmd_reg;
    assign now_out       = now_reg;

endmodule
